// ===== src/rnc_pkg.sv =====
package rnc_pkg;

    localparam int MAX_LEN   = 15;
    localparam int VALUE_MAX = 3999;
    localparam int TOTAL_MAX = 16383;
    localparam int CNT_MAX   = 31;
    localparam int RUN_MAX   = 7;
    localparam int RUN_LIMIT = 3;

    typedef enum logic [2:0] {
        SYM_NONE = 3'd0,
        SYM_I    = 3'd1,
        SYM_V    = 3'd2,
        SYM_X    = 3'd3,
        SYM_L    = 3'd4,
        SYM_C    = 3'd5,
        SYM_D    = 3'd6,
        SYM_M    = 3'd7
    } t_sym;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_LEN    = 3'd1,
        ST_BAD_CHAR   = 3'd2,
        ST_BAD_FORMAT = 3'd3,
        ST_RANGE      = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [11:0] value;
        t_status     status;
    } t_out;

    function automatic t_sym decode(input logic [7:0] c);
        t_sym s;
        unique case (c)
            8'h49:   s = SYM_I;
            8'h56:   s = SYM_V;
            8'h58:   s = SYM_X;
            8'h4C:   s = SYM_L;
            8'h43:   s = SYM_C;
            8'h44:   s = SYM_D;
            8'h4D:   s = SYM_M;
            default: s = SYM_NONE;
        endcase
        return s;
    endfunction

    function automatic logic [9:0] sym_value(input t_sym s);
        logic [9:0] v;
        unique case (s)
            SYM_I:   v = 10'd1;
            SYM_V:   v = 10'd5;
            SYM_X:   v = 10'd10;
            SYM_L:   v = 10'd50;
            SYM_C:   v = 10'd100;
            SYM_D:   v = 10'd500;
            SYM_M:   v = 10'd1000;
            default: v = 10'd0;
        endcase
        return v;
    endfunction

    function automatic logic may_precede(input t_sym p, input t_sym c);
        logic ok;
        unique case (p)
            SYM_I:   ok = (c == SYM_V) || (c == SYM_X);
            SYM_X:   ok = (c == SYM_L) || (c == SYM_C);
            SYM_C:   ok = (c == SYM_D) || (c == SYM_M);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ===== src/roman_numeral_checker_converter.sv =====
// The last character passes through the input register; o_valid rises when its result
// loads into the result register, and the result transfers from there once i_stall is low.
// Throughput: one character per cycle; the single-pass update sits between
// the input register and the result register.
// A held result only blocks the pipe when the next item also ends a numeral.
// Reset (i_rst_n low, synchronous) empties both registers and clears the scan state.
module roman_numeral_checker_converter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rnc_pkg::t_in  i_item,
    output logic          o_valid,
    input  logic          i_stall,
    output rnc_pkg::t_out o_item
);

    logic          in_vld;
    rnc_pkg::t_in  in_item;
    logic          out_busy;
    logic          advance;
    logic          step;
    rnc_pkg::t_out res;

    assign advance = !in_item.last || !out_busy;
    assign step    = in_vld && advance;

    rnc_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (i_item),
        .i_advance (advance),
        .o_vld     (in_vld),
        .o_item    (in_item)
    );

    rnc_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (in_item),
        .o_res   (res)
    );

    rnc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && in_item.last),
        .i_res   (res),
        .i_stall (i_stall),
        .o_busy  (out_busy),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    a_ok_has_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status == rnc_pkg::ST_OK |-> o_item.value != 12'd0)
        else $error("accepted numeral with zero value");

    a_err_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status != rnc_pkg::ST_OK |-> o_item.value == 12'd0)
        else $error("rejected numeral carries a value");

endmodule

// ===== src/rnc_in_stage.sv =====
module rnc_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rnc_pkg::t_in  i_item,
    input  logic          i_advance,
    output logic          o_vld,
    output rnc_pkg::t_in  o_item
);

    logic         r_vld;
    rnc_pkg::t_in r_item;

    assign o_stall = r_vld && !i_advance;
    assign o_vld   = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_stall) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== src/rnc_scan.sv =====
module rnc_scan (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  rnc_pkg::t_in  i_item,
    output rnc_pkg::t_out o_res
);

    logic [4:0]     r_cnt,   n_cnt;
    logic           r_long,  n_long;
    rnc_pkg::t_sym  r_prev,  n_prev;
    rnc_pkg::t_sym  r_pprev, n_pprev;
    rnc_pkg::t_sym  r_pend,  n_pend;
    logic [2:0]     r_run,   n_run;
    logic           r_cerr,  n_cerr;
    logic           r_ferr,  n_ferr;
    logic [13:0]    r_total, n_total;

    rnc_pkg::t_sym  sym;
    logic [9:0]     v_cur;
    logic [9:0]     v_prev;
    logic [9:0]     v_pend;
    logic [9:0]     add_v;
    logic [14:0]    sum_a;
    logic [13:0]    tot_a;
    logic [14:0]    sum_f;
    logic [13:0]    tot_f;

    assign sym    = rnc_pkg::decode(i_item.ch);
    assign v_cur  = rnc_pkg::sym_value(sym);
    assign v_prev = rnc_pkg::sym_value(r_prev);
    assign v_pend = rnc_pkg::sym_value(r_pend);

    always_comb begin
        n_cnt   = r_cnt;
        n_long  = r_long;
        n_prev  = r_prev;
        n_pprev = r_pprev;
        n_pend  = r_pend;
        n_run   = r_run;
        n_cerr  = r_cerr;
        n_ferr  = r_ferr;
        add_v   = '0;

        if (i_item.has_char) begin
            if (r_cnt == 5'(rnc_pkg::CNT_MAX)) begin
                n_long = 1'b1;
            end else begin
                n_cnt = r_cnt + 5'd1;
            end
            if (sym == rnc_pkg::SYM_NONE) begin
                n_cerr  = 1'b1;
                n_pprev = r_prev;
                n_prev  = rnc_pkg::SYM_NONE;
            end else begin
                n_run = 3'd1;
                if (r_prev != rnc_pkg::SYM_NONE) begin
                    if (v_prev < v_cur) begin
                        if (!rnc_pkg::may_precede(r_prev, sym)) begin
                            n_ferr = 1'b1;
                        end
                    end else if (v_prev > v_cur && r_pprev != rnc_pkg::SYM_NONE
                                 && r_pprev == sym) begin
                        n_ferr = 1'b1;
                    end
                    if (r_prev == sym) begin
                        if (sym == rnc_pkg::SYM_I || sym == rnc_pkg::SYM_X ||
                            sym == rnc_pkg::SYM_C || sym == rnc_pkg::SYM_M) begin
                            n_run = (r_run < 3'(rnc_pkg::RUN_MAX)) ? r_run + 3'd1 : r_run;
                            if (n_run > 3'(rnc_pkg::RUN_LIMIT)) begin
                                n_ferr = 1'b1;
                            end
                        end else begin
                            n_run  = r_run;
                            n_ferr = 1'b1;
                        end
                    end
                end
                if (r_pend == rnc_pkg::SYM_NONE) begin
                    n_pend = sym;
                end else if (v_pend < v_cur) begin
                    add_v  = v_cur - v_pend;
                    n_pend = rnc_pkg::SYM_NONE;
                end else begin
                    add_v  = v_pend;
                    n_pend = sym;
                end
                n_pprev = r_prev;
                n_prev  = sym;
            end
        end
    end

    // saturating accumulate, then the flush of a pending symbol at end of numeral
    assign sum_a = {1'b0, r_total} + 15'(add_v);
    assign tot_a = (sum_a > 15'(rnc_pkg::TOTAL_MAX)) ? 14'(rnc_pkg::TOTAL_MAX) : sum_a[13:0];
    assign sum_f = {1'b0, tot_a} + 15'(rnc_pkg::sym_value(n_pend));
    assign tot_f = (sum_f > 15'(rnc_pkg::TOTAL_MAX)) ? 14'(rnc_pkg::TOTAL_MAX) : sum_f[13:0];
    assign n_total = tot_a;

    always_comb begin
        o_res.value  = '0;
        o_res.status = rnc_pkg::ST_OK;
        if (n_cnt == 5'd0 || n_long || n_cnt > 5'(rnc_pkg::MAX_LEN)) begin
            o_res.status = rnc_pkg::ST_BAD_LEN;
        end else if (n_cerr) begin
            o_res.status = rnc_pkg::ST_BAD_CHAR;
        end else if (n_ferr) begin
            o_res.status = rnc_pkg::ST_BAD_FORMAT;
        end else if (tot_f == 14'd0 || tot_f > 14'(rnc_pkg::VALUE_MAX)) begin
            o_res.status = rnc_pkg::ST_RANGE;
        end else begin
            o_res.value = tot_f[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last)) begin
            r_cnt   <= '0;
            r_long  <= 1'b0;
            r_prev  <= rnc_pkg::SYM_NONE;
            r_pprev <= rnc_pkg::SYM_NONE;
            r_pend  <= rnc_pkg::SYM_NONE;
            r_run   <= 3'd1;
            r_cerr  <= 1'b0;
            r_ferr  <= 1'b0;
            r_total <= '0;
        end else if (i_step) begin
            r_cnt   <= n_cnt;
            r_long  <= n_long;
            r_prev  <= n_prev;
            r_pprev <= n_pprev;
            r_pend  <= n_pend;
            r_run   <= n_run;
            r_cerr  <= n_cerr;
            r_ferr  <= n_ferr;
            r_total <= n_total;
        end
    end

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run != 3'd0)
        else $error("run length is zero");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.last |=> r_cnt == 5'd0 && r_total == 14'd0 &&
        r_pend == rnc_pkg::SYM_NONE)
        else $error("state not cleared after end of numeral");

endmodule

// ===== src/rnc_out_stage.sv =====
module rnc_out_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  rnc_pkg::t_out i_res,
    input  logic          i_stall,
    output logic          o_busy,
    output logic          o_valid,
    output rnc_pkg::t_out o_item
);

    logic          r_vld;
    rnc_pkg::t_out r_item;

    assign o_busy  = r_vld && i_stall;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_res;
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int CHAR_TARGET = 1800;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 10;

    localparam int RX_FREE  = 0;
    localparam int RX_LIGHT = 1;
    localparam int RX_HEAVY = 2;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          i_stall = 1'b0;
    rnc_pkg::t_in  i_item  = '0;
    logic          o_stall;
    logic          o_valid;
    rnc_pkg::t_out o_item;

    roman_numeral_checker_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // stimulus and predicted conversions
    rnc_pkg::t_in  char_stream[$];
    rnc_pkg::t_out predicted_conversions[$];
    byte unsigned  numeral[$];
    byte unsigned  roman_letters[7] = '{"I", "V", "X", "L", "C", "D", "M"};
    int            symbol_chars;
    int            total_items;
    int            accepted_items;
    int            checked_results;
    int            mismatches;
    int            status_hits[5];
    int            idle_cycles;
    bit            item_taken;

    // converter state, mirrored
    logic [4:0]    num_len;
    bit            len_overflow;
    rnc_pkg::t_sym last_sym;
    rnc_pkg::t_sym sym_before_last;
    rnc_pkg::t_sym held_sym;
    logic [2:0]    repeat_len;
    bit            saw_bad_char;
    bit            saw_bad_form;
    logic [13:0]   greedy_sum;

    function automatic int unsigned weight(input rnc_pkg::t_sym s);
        case (s)
            rnc_pkg::SYM_I: return 1;
            rnc_pkg::SYM_V: return 5;
            rnc_pkg::SYM_X: return 10;
            rnc_pkg::SYM_L: return 50;
            rnc_pkg::SYM_C: return 100;
            rnc_pkg::SYM_D: return 500;
            rnc_pkg::SYM_M: return 1000;
            default:        return 0;
        endcase
    endfunction

    function automatic rnc_pkg::t_sym symbol_of(input logic [7:0] c);
        case (c)
            "I":     return rnc_pkg::SYM_I;
            "V":     return rnc_pkg::SYM_V;
            "X":     return rnc_pkg::SYM_X;
            "L":     return rnc_pkg::SYM_L;
            "C":     return rnc_pkg::SYM_C;
            "D":     return rnc_pkg::SYM_D;
            "M":     return rnc_pkg::SYM_M;
            default: return rnc_pkg::SYM_NONE;
        endcase
    endfunction

    // I, X and C may stand before the next two larger symbols only
    function automatic bit subtractive_ok(input rnc_pkg::t_sym p, input rnc_pkg::t_sym c);
        bit base;
        base = (p == rnc_pkg::SYM_I) || (p == rnc_pkg::SYM_X) || (p == rnc_pkg::SYM_C);
        return base && ((weight(c) == 5 * weight(p)) || (weight(c) == 10 * weight(p)));
    endfunction

    task automatic clear_scan();
        num_len         = '0;
        len_overflow    = 1'b0;
        last_sym        = rnc_pkg::SYM_NONE;
        sym_before_last = rnc_pkg::SYM_NONE;
        held_sym        = rnc_pkg::SYM_NONE;
        repeat_len      = 3'd1;
        saw_bad_char    = 1'b0;
        saw_bad_form    = 1'b0;
        greedy_sum      = '0;
    endtask

    task automatic add_sum(input int unsigned v);
        int unsigned t;
        t = greedy_sum + v;
        greedy_sum = (t > rnc_pkg::TOTAL_MAX) ? 14'(rnc_pkg::TOTAL_MAX) : 14'(t);
    endtask

    task automatic absorb_symbol(input rnc_pkg::t_sym c);
        rnc_pkg::t_sym p;
        int unsigned   vc;
        int unsigned   vp;
        p  = last_sym;
        vc = weight(c);
        vp = weight(p);
        if (p != rnc_pkg::SYM_NONE) begin
            if (vp < vc) begin
                if (!subtractive_ok(p, c))
                    saw_bad_form = 1'b1;
            end else if (vp > vc && sym_before_last != rnc_pkg::SYM_NONE
                         && sym_before_last == c) begin
                saw_bad_form = 1'b1;
            end
            if (p == c) begin
                if (c == rnc_pkg::SYM_I || c == rnc_pkg::SYM_X ||
                    c == rnc_pkg::SYM_C || c == rnc_pkg::SYM_M) begin
                    if (repeat_len < rnc_pkg::RUN_MAX)
                        repeat_len = repeat_len + 3'd1;
                    if (repeat_len > rnc_pkg::RUN_LIMIT)
                        saw_bad_form = 1'b1;
                end else begin
                    saw_bad_form = 1'b1;
                end
            end else begin
                repeat_len = 3'd1;
            end
        end else begin
            repeat_len = 3'd1;
        end
        if (held_sym == rnc_pkg::SYM_NONE) begin
            held_sym = c;
        end else if (weight(held_sym) < vc) begin
            add_sum(vc - weight(held_sym));
            held_sym = rnc_pkg::SYM_NONE;
        end else begin
            add_sum(weight(held_sym));
            held_sym = c;
        end
        sym_before_last = p;
        last_sym        = c;
    endtask

    task automatic convert_char(input rnc_pkg::t_in it, output bit ready,
                                output rnc_pkg::t_out res);
        rnc_pkg::t_sym s;
        ready = 1'b0;
        res   = '0;
        if (it.has_char) begin
            s = symbol_of(it.ch);
            if (num_len == 5'(rnc_pkg::CNT_MAX))
                len_overflow = 1'b1;
            else
                num_len = num_len + 5'd1;
            if (s == rnc_pkg::SYM_NONE) begin
                saw_bad_char    = 1'b1;
                sym_before_last = last_sym;
                last_sym        = rnc_pkg::SYM_NONE;
            end else begin
                absorb_symbol(s);
            end
        end
        if (it.last) begin
            if (held_sym != rnc_pkg::SYM_NONE)
                add_sum(weight(held_sym));
            if (num_len == 0 || len_overflow || num_len > rnc_pkg::MAX_LEN)
                res.status = rnc_pkg::ST_BAD_LEN;
            else if (saw_bad_char)
                res.status = rnc_pkg::ST_BAD_CHAR;
            else if (saw_bad_form)
                res.status = rnc_pkg::ST_BAD_FORMAT;
            else if (greedy_sum < 1 || greedy_sum > rnc_pkg::VALUE_MAX)
                res.status = rnc_pkg::ST_RANGE;
            else begin
                res.status = rnc_pkg::ST_OK;
                res.value  = greedy_sum[11:0];
            end
            ready = 1'b1;
            clear_scan();
        end
    endtask

    // numeral building
    task automatic append_digit(input int d, input byte unsigned one,
                                input byte unsigned five, input byte unsigned ten);
        if (d == 9) begin
            numeral.push_back(one);
            numeral.push_back(ten);
        end else if (d == 4) begin
            numeral.push_back(one);
            numeral.push_back(five);
        end else begin
            if (d >= 5)
                numeral.push_back(five);
            repeat (d % 5) numeral.push_back(one);
        end
    endtask

    task automatic append_roman(input int n);
        repeat (n / 1000) numeral.push_back("M");
        append_digit((n / 100) % 10, "C", "D", "M");
        append_digit((n / 10) % 10, "X", "L", "C");
        append_digit(n % 10, "I", "V", "X");
    endtask

    function automatic byte unsigned any_letter();
        return roman_letters[$urandom_range(0, 6)];
    endfunction

    function automatic int pick_value();
        int r;
        r = $urandom_range(0, 3);
        if (r < 2)
            return $urandom_range(1, 50);
        else if (r == 2)
            return $urandom_range(1, 400);
        return $urandom_range(1, 3999);
    endfunction

    task automatic mutate_numeral();
        int pos;
        pos = $urandom_range(0, numeral.size() - 1);
        case ($urandom_range(0, 3))
            0: numeral[pos] = any_letter();
            1: numeral.insert(pos, any_letter());
            2: if (numeral.size() > 1) numeral.delete(pos);
               else numeral.push_back(any_letter());
            default: numeral.insert(pos, numeral[pos]);
        endcase
    endtask

    task automatic queue_numeral(input bit end_alone);
        rnc_pkg::t_in it;
        foreach (numeral[i]) begin
            if ($urandom_range(0, 19) == 0) begin
                it = '{8'($urandom_range(0, 255)), 1'b0, 1'b0};
                char_stream.push_back(it);
            end
            it = '{numeral[i], 1'b1, (i == numeral.size() - 1) && !end_alone};
            char_stream.push_back(it);
            symbol_chars++;
        end
        if (end_alone) begin
            it = '{8'($urandom_range(0, 255)), 1'b0, 1'b1};
            char_stream.push_back(it);
            symbol_chars++;
        end
    endtask

    task automatic queue_text(input string s, input bit end_alone);
        numeral.delete();
        for (int i = 0; i < s.len(); i++)
            numeral.push_back(s[i]);
        queue_numeral(end_alone);
    endtask

    // sender: bursts and gaps, payload held while stalled
    int burst_left;
    int gap_left;

    always @(negedge i_clk) begin
        bit           v;
        rnc_pkg::t_in nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (item_taken)
                void'(char_stream.pop_front());
            v   = 1'b0;
            nxt = i_item;
            if (i_valid && !item_taken) begin
                v = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (char_stream.size() > 0) begin
                v   = 1'b1;
                nxt = char_stream[0];
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 9))
                        0, 1, 2: gap_left = 0;
                        9:       gap_left = $urandom_range(10, 25);
                        default: gap_left = $urandom_range(1, 6);
                    endcase
                end else begin
                    burst_left--;
                end
            end
            i_valid <= v;
            i_item  <= nxt;
        end
    end

    // receiver stall pattern
    int stall_mode;
    int stall_span;

    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(RX_FREE, RX_HEAVY);
            stall_span = $urandom_range(20, 200);
        end else begin
            stall_span--;
        end
        case (stall_mode)
            RX_FREE:  i_stall <= 1'b0;
            RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            default:  i_stall <= ($urandom_range(0, 4) != 0);
        endcase
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        bit            ready;
        rnc_pkg::t_out res;
        rnc_pkg::t_out want;
        bit            moved;
        item_taken = 1'b0;
        moved      = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                item_taken = 1'b1;
                moved      = 1'b1;
                accepted_items++;
                convert_char(i_item, ready, res);
                if (ready)
                    predicted_conversions.push_back(res);
            end
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                if (predicted_conversions.size() == 0) begin
                    $display("%0t: result with none pending: expected nothing, %s",
                             $time, "got");
                    $display("%0t:   value %0d status %0d",
                             $time, o_item.value, o_item.status);
                    mismatches++;
                end else begin
                    want = predicted_conversions.pop_front();
                    checked_results++;
                    status_hits[want.status]++;
                    if (o_item.value !== want.value) begin
                        $display("%0t: value mismatch: expected %0d, got %0d",
                                 $time, want.value, o_item.value);
                        mismatches++;
                    end
                    if (o_item.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d (%s), got %0d",
                                 $time, want.status, want.status.name(), o_item.status);
                        mismatches++;
                    end
                end
            end
            if (moved) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                             $time, IDLE_LIMIT, predicted_conversions.size());
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    initial begin
        int pick;
        int len;
        clear_scan();

        // directed numerals
        queue_text("", 1'b1);
        queue_text("I", 1'b0);
        queue_text("MMMCMXCIX", 1'b0);
        char_stream.insert(5, rnc_pkg::t_in'{8'hFF, 1'b0, 1'b0});
        queue_text("IIII", 1'b0);
        queue_text("i", 1'b0);
        queue_text("VV", 1'b0);
        queue_text("IXI", 1'b0);
        queue_text("IL", 1'b1);
        queue_text("MMMCMM", 1'b0);

        while (symbol_chars < CHAR_TARGET) begin
            numeral.delete();
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                append_roman(pick_value());
            end else if (pick < 65) begin
                append_roman(pick_value());
                mutate_numeral();
                if ($urandom_range(0, 1) == 0)
                    mutate_numeral();
            end else if (pick < 77) begin
                repeat ($urandom_range(1, 8)) numeral.push_back(any_letter());
            end else if (pick < 83) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 40)
                                                  : $urandom_range(14, 18);
                repeat (len) numeral.push_back(any_letter());
            end else if (pick < 94) begin
                append_roman(pick_value());
                len = $urandom_range(0, numeral.size() - 1);
                if ($urandom_range(0, 1) == 0)
                    numeral[len] = 8'($urandom_range(0, 255));
                else
                    numeral[len] = roman_letters[$urandom_range(0, 6)] + 8'h20;
            end
            queue_numeral((numeral.size() == 0) || ($urandom_range(0, 4) == 0));
        end
        total_items = char_stream.size();

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
            #1;
        end while (accepted_items < total_items || predicted_conversions.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d items transferred, %0d numerals converted and checked", accepted_items,
                 checked_results);
        $display("status spread: ok %0d, length %0d, char %0d, format %0d, range %0d",
                 status_hits[rnc_pkg::ST_OK], status_hits[rnc_pkg::ST_BAD_LEN],
                 status_hits[rnc_pkg::ST_BAD_CHAR], status_hits[rnc_pkg::ST_BAD_FORMAT],
                 status_hits[rnc_pkg::ST_RANGE]);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== roman_numeral_checker_converter.f =====
src/rnc_pkg.sv
src/rnc_in_stage.sv
src/rnc_scan.sv
src/rnc_out_stage.sv
src/roman_numeral_checker_converter.sv
tb/sv/tb_top.sv
